### rtl/slp_pkg.sv
// Shared types and constants for the stereo landmark projection unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package slp_pkg;

  // Queue sizes
  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = 3;
  localparam int MQ_CW    = 4;
  localparam int OQ_DEPTH = 32;
  localparam int OQ_AW    = 5;
  localparam int OQ_CW    = 6;

  // Front datapath widths
  localparam int FS   = 6;   // front stages
  localparam int DW   = 33;  // world delta
  localparam int EW   = 35;  // rotation entry before rounding, Q.28
  localparam int RW   = 20;  // rotation entry, Q.14
  localparam int PW1  = 53;  // delta times rotation entry
  localparam int BSW  = PW1 + 2;
  localparam int BW   = 40;  // body point, Q16.16
  localparam int PW2  = 56;  // camera rotation times body point
  localparam int CSW  = PW2 + 2;
  localparam int CW   = 44;  // camera point, Q16.16
  localparam int OFW  = 20;  // packed offset entry, Q8.12
  localparam int RND_HALF = 8192;

  // Back datapath widths
  localparam int XW   = 45;  // numerator coordinate
  localparam int NW   = 60;  // numerator magnitude
  localparam int ZW   = 43;  // depth magnitude
  localparam int QB   = 17;  // quotient bits kept
  localparam int UW   = 20;  // pixel before bounds check
  localparam int LANES = 4;

  // Lane order of the four divisions
  localparam int LN_LU = 0;
  localparam int LN_LV = 1;
  localparam int LN_RU = 2;
  localparam int LN_RV = 3;

  typedef enum logic [2:0] {
    REG_ROT_A    = 3'd0,
    REG_ROT_B    = 3'd1,
    REG_ROT_C    = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_BASELINE = 3'd4,
    REG_INTR_L   = 3'd5,
    REG_INTR_R   = 3'd6,
    REG_SIZES    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][47:0] rot;
    logic [59:0]      offset;
    logic [19:0]      baseline;
    logic [59:0]      intr_l;
    logic [59:0]      intr_r;
    logic [59:0]      sizes;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         id;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } in_item_t;

  typedef struct packed {
    logic [9:0]           id;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } mid_item_t;

  typedef struct packed {
    logic [9:0]  id;
    logic [15:0] lu;
    logic [15:0] lv;
    logic [15:0] ru;
    logic [15:0] rv;
    logic [15:0] disp;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/slp_front.sv
// Front pipeline: world point to cam0 frame, drops points behind the cameras.
// Depends on slp_pkg; feeds slp_midq and keeps its credit count.
`default_nettype none
module slp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  slp_pkg::cfg_t       cfg,
  input  logic                in_acc,
  input  slp_pkg::in_item_t   in_item,
  input  logic                mq_pop,
  output logic                full,
  output logic                mq_push,
  output slp_pkg::mid_item_t  mq_data
);
  import slp_pkg::*;

  localparam logic signed [EW-1:0] ONE_Q28 = EW'(1 <<< 28);

  logic [FS-1:0]       vld_r;
  logic [MQ_CW-1:0]    occ_r, occ_nxt;
  logic                drop;

  logic [9:0]           s0_id_r, s1_id_r, s2_id_r, s3_id_r, s4_id_r, s5_id_r;
  logic signed [DW-1:0] s0_d_r [3];
  logic signed [DW-1:0] s1_d_r [3];
  logic signed [15:0]   s0_q_r [4];
  logic signed [RW-1:0] s1_r_r [3][3];
  logic signed [PW1-1:0] s2_pr_r [3][3];
  logic signed [BW-1:0] s3_b_r [3];
  logic signed [PW2-1:0] s4_pc_r [3][3];
  logic signed [CW-1:0] s5_c_r [3];

  logic signed [31:0]   pxx, pyy, pzz, pxy, pwz, pxz, pwy, pyz, pwx;
  logic signed [EW-1:0] e [3][3];
  logic signed [EW-1:0] e_rnd [3][3];
  logic signed [BSW-1:0] bsum [3];
  logic signed [CSW-1:0] csum [3];
  logic signed [15:0]   rot [3][3];
  logic signed [OFW-1:0] off [3];

  // Quaternion products and the Q.28 rotation entries
  always_comb begin
    pxx = s0_q_r[1] * s0_q_r[1];
    pyy = s0_q_r[2] * s0_q_r[2];
    pzz = s0_q_r[3] * s0_q_r[3];
    pxy = s0_q_r[1] * s0_q_r[2];
    pwz = s0_q_r[0] * s0_q_r[3];
    pxz = s0_q_r[1] * s0_q_r[3];
    pwy = s0_q_r[0] * s0_q_r[2];
    pyz = s0_q_r[2] * s0_q_r[3];
    pwx = s0_q_r[0] * s0_q_r[1];
    e[0][0] = ONE_Q28 - ((EW'(pyy) + EW'(pzz)) <<< 1);
    e[0][1] = (EW'(pxy) - EW'(pwz)) <<< 1;
    e[0][2] = (EW'(pxz) + EW'(pwy)) <<< 1;
    e[1][0] = (EW'(pxy) + EW'(pwz)) <<< 1;
    e[1][1] = ONE_Q28 - ((EW'(pxx) + EW'(pzz)) <<< 1);
    e[1][2] = (EW'(pyz) - EW'(pwx)) <<< 1;
    e[2][0] = (EW'(pxz) - EW'(pwy)) <<< 1;
    e[2][1] = (EW'(pyz) + EW'(pwx)) <<< 1;
    e[2][2] = ONE_Q28 - ((EW'(pxx) + EW'(pyy)) <<< 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e_rnd[i][j] = (e[i][j] + EW'(RND_HALF)) >>> 14;
      end
    end
  end

  // Product sums, rounded half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsum[i] = BSW'(s2_pr_r[i][0]) + BSW'(s2_pr_r[i][1]) + BSW'(s2_pr_r[i][2])
              + BSW'(RND_HALF);
      csum[i] = CSW'(s4_pc_r[i][0]) + CSW'(s4_pc_r[i][1]) + CSW'(s4_pc_r[i][2])
              + CSW'(RND_HALF);
      off[i] = $signed(cfg.offset[OFW*i +: OFW]);
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = $signed(cfg.rot[i][16*j +: 16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_id_r   <= in_item.id;
    s0_d_r[0] <= DW'(in_item.px) - DW'(in_item.bx);
    s0_d_r[1] <= DW'(in_item.py) - DW'(in_item.by);
    s0_d_r[2] <= DW'(in_item.pz) - DW'(in_item.bz);
    s0_q_r[0] <= in_item.qw;
    s0_q_r[1] <= in_item.qx;
    s0_q_r[2] <= in_item.qy;
    s0_q_r[3] <= in_item.qz;

    s1_id_r <= s0_id_r;
    s2_id_r <= s1_id_r;
    s3_id_r <= s2_id_r;
    s4_id_r <= s3_id_r;
    s5_id_r <= s4_id_r;
    for (int i = 0; i < 3; i++) begin
      s1_d_r[i] <= s0_d_r[i];
      s3_b_r[i] <= BW'(bsum[i] >>> 14);
      s5_c_r[i] <= CW'(csum[i] >>> 14) + (CW'(off[i]) <<< 4);
      for (int j = 0; j < 3; j++) begin
        s1_r_r[i][j]  <= RW'(e_rnd[i][j]);
        // body frame uses the transpose
        s2_pr_r[i][j] <= s1_r_r[j][i] * s1_d_r[j];
        s4_pc_r[i][j] <= rot[i][j] * s3_b_r[j];
      end
    end
  end

  // Drop points with no positive depth; both cameras share it
  assign mq_push = vld_r[FS-1] && !s5_c_r[2][CW-1] && (|s5_c_r[2]);
  assign drop    = vld_r[FS-1] && !mq_push;
  assign mq_data = '{id: s5_id_r, cx: s5_c_r[0], cy: s5_c_r[1], cz: s5_c_r[2]};

  // Credits cover the pipeline plus the queue behind it
  assign occ_nxt = occ_r + MQ_CW'(in_acc) - MQ_CW'(mq_pop) - MQ_CW'(drop);
  assign full    = (occ_r == MQ_CW'(MQ_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      occ_r <= '0;
    end else begin
      vld_r <= {vld_r[FS-2:0], in_acc};
      occ_r <= occ_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/slp_midq.sv
// Queue between the front and back pipelines, one camera point per word.
// Depends on slp_pkg.
`default_nettype none
module slp_midq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slp_pkg::mid_item_t din,
  input  logic               pop,
  output slp_pkg::mid_item_t dout,
  output logic               empty
);
  import slp_pkg::*;

  mid_item_t        mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wp_r, rp_r;
  logic [MQ_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + MQ_CW'(push) - MQ_CW'(pop);
    end
  end

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == '0);

endmodule
`default_nettype wire

### rtl/slp_back.sv
// Back pipeline: four pipelined dividers project into both cameras, then the
// bounds and disparity checks. Depends on slp_pkg; reads slp_midq, fills slp_outq.
`default_nettype none
module slp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slp_pkg::cfg_t      cfg,
  input  logic               mq_empty,
  input  slp_pkg::mid_item_t mq_data,
  output logic               mq_pop,
  input  logic               oq_pop,
  output logic               oq_push,
  output slp_pkg::out_item_t oq_data
);
  import slp_pkg::*;

  logic [OQ_CW-1:0] occ_r, occ_nxt;
  logic             drop, keep;

  logic                 b0_v_r, b1_v_r, b2_v_r, f_v_r;
  logic [9:0]           b0_id_r, b1_id_r, b2_id_r, f_id_r;
  logic signed [XW-1:0] b0_x_r [LANES];
  logic [ZW-1:0]        b0_z_r, b1_z_r, b2_z_r;
  logic signed [NW-1:0] b1_n_r [LANES];
  logic                 b2_neg_r [LANES];
  logic [NW-1:0]        b2_mag_r [LANES];

  logic [QB:0]          dv_v_r;
  logic [9:0]           dv_id_r  [QB+1];
  logic [ZW-1:0]        dv_z_r   [QB+1];
  logic                 dv_neg_r [QB+1][LANES];
  logic                 dv_ovf_r [QB+1][LANES];
  logic [NW-1:0]        dv_rem_r [QB+1][LANES];
  logic [QB-1:0]        dv_quo_r [QB+1][LANES];

  logic                 f_ok_r  [LANES];
  logic signed [UW-1:0] f_pix_r [LANES];

  logic [14:0]          foc [LANES];
  logic [14:0]          cpt [LANES];
  logic [11:0]          lim [LANES];
  logic [UW-1:0]        qabs [LANES];
  logic                 inb [LANES];
  logic [16:0]          disp;

  always_comb begin
    foc[LN_LU] = cfg.intr_l[14:0];
    foc[LN_LV] = cfg.intr_l[29:15];
    foc[LN_RU] = cfg.intr_r[14:0];
    foc[LN_RV] = cfg.intr_r[29:15];
    cpt[LN_LU] = cfg.intr_l[44:30];
    cpt[LN_LV] = cfg.intr_l[59:45];
    cpt[LN_RU] = cfg.intr_r[44:30];
    cpt[LN_RV] = cfg.intr_r[59:45];
    lim[LN_LU] = cfg.sizes[11:0];
    lim[LN_LV] = cfg.sizes[23:12];
    lim[LN_RU] = cfg.sizes[35:24];
    lim[LN_RV] = cfg.sizes[47:36];
  end

  // Issue only while the output queue has room for everything in flight
  assign mq_pop = !mq_empty && (occ_r != OQ_CW'(OQ_DEPTH));

  always_ff @(posedge clk) begin
    b0_id_r <= mq_data.id;
    b0_x_r[LN_LU] <= XW'(mq_data.cx);
    b0_x_r[LN_LV] <= XW'(mq_data.cy);
    b0_x_r[LN_RU] <= XW'(mq_data.cx) - XW'({cfg.baseline, 4'b0000});
    b0_x_r[LN_RV] <= XW'(mq_data.cy);
    b0_z_r  <= mq_data.cz[ZW-1:0];

    b1_id_r <= b0_id_r;
    b1_z_r  <= b0_z_r;
    b2_id_r <= b1_id_r;
    b2_z_r  <= b1_z_r;
    for (int l = 0; l < LANES; l++) begin
      b1_n_r[l]   <= $signed({1'b0, foc[l]}) * b0_x_r[l];
      b2_neg_r[l] <= b1_n_r[l][NW-1];
      b2_mag_r[l] <= b1_n_r[l][NW-1] ? NW'(-b1_n_r[l]) : NW'(b1_n_r[l]);
    end

    // First divider stage flags quotients too large for any image
    dv_id_r[0] <= b2_id_r;
    dv_z_r[0]  <= b2_z_r;
    for (int l = 0; l < LANES; l++) begin
      dv_neg_r[0][l] <= b2_neg_r[l];
      dv_ovf_r[0][l] <= (b2_mag_r[l] >= (NW'(b2_z_r) << QB));
      dv_rem_r[0][l] <= b2_mag_r[l];
      dv_quo_r[0][l] <= '0;
    end

    // One quotient bit per stage, most significant first
    for (int s = 1; s <= QB; s++) begin
      dv_id_r[s] <= dv_id_r[s-1];
      dv_z_r[s]  <= dv_z_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        dv_neg_r[s][l] <= dv_neg_r[s-1][l];
        dv_ovf_r[s][l] <= dv_ovf_r[s-1][l];
        if (dv_rem_r[s-1][l] >= (NW'(dv_z_r[s-1]) << (QB - s))) begin
          dv_rem_r[s][l] <= dv_rem_r[s-1][l] - (NW'(dv_z_r[s-1]) << (QB - s));
          dv_quo_r[s][l] <= dv_quo_r[s-1][l] | (QB'(1) << (QB - s));
        end else begin
          dv_rem_r[s][l] <= dv_rem_r[s-1][l];
          dv_quo_r[s][l] <= dv_quo_r[s-1][l];
        end
      end
    end

    f_id_r <= dv_id_r[QB];
    for (int l = 0; l < LANES; l++) begin
      f_ok_r[l]  <= !dv_ovf_r[QB][l];
      f_pix_r[l] <= (dv_neg_r[QB][l] ? -qabs[l] : qabs[l]) + UW'(cpt[l]);
    end
  end

  // Floor rounding: a negative quotient with a remainder steps down one more
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qabs[l] = UW'(dv_quo_r[QB][l]) + UW'(dv_neg_r[QB][l] && (|dv_rem_r[QB][l]));
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      inb[l] = f_ok_r[l] && !f_pix_r[l][UW-1]
               && (f_pix_r[l][UW-2:0] < (UW-1)'({lim[l], 4'b0000}));
    end
    disp = {1'b0, f_pix_r[LN_LU][15:0]} - {1'b0, f_pix_r[LN_RU][15:0]};
    keep = inb[LN_LU] && inb[LN_LV] && inb[LN_RU] && inb[LN_RV]
           && !disp[16] && (disp[15:0] > {4'b0000, cfg.sizes[59:48]});
  end

  assign oq_push = f_v_r && keep;
  assign drop    = f_v_r && !keep;
  assign oq_data = '{id:   f_id_r,
                     lu:   f_pix_r[LN_LU][15:0],
                     lv:   f_pix_r[LN_LV][15:0],
                     ru:   f_pix_r[LN_RU][15:0],
                     rv:   f_pix_r[LN_RV][15:0],
                     disp: disp[15:0]};

  assign occ_nxt = occ_r + OQ_CW'(mq_pop) - OQ_CW'(oq_pop) - OQ_CW'(drop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      dv_v_r <= '0;
      f_v_r  <= 1'b0;
      occ_r  <= '0;
    end else begin
      b0_v_r <= mq_pop;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
      dv_v_r <= {dv_v_r[QB-1:0], b2_v_r};
      f_v_r  <= dv_v_r[QB];
      occ_r  <= occ_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/slp_outq.sv
// Result queue: holds finished words until the receiver pops them.
// Depends on slp_pkg.
`default_nettype none
module slp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slp_pkg::out_item_t din,
  input  logic               pop,
  output slp_pkg::out_item_t dout,
  output logic               empty
);
  import slp_pkg::*;

  out_item_t        mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, rp_r;
  logic [OQ_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + OQ_CW'(push) - OQ_CW'(pop);
    end
  end

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == '0);

endmodule
`default_nettype wire

### rtl/stereo_landmark_projection_unit.sv
// Stereo landmark projection unit.
// Input words (push/full) carry a landmark and the body pose; accepted when
// push is high and full is low. Result words (empty/pop) carry the landmark
// id, the cam0 and cam1 pixels and the disparity; the oldest is on the out_
// ports while empty is low and leaves when pop is high.
// Landmarks that are out of view in either camera, have no positive depth, or
// are at or below the disparity limit produce no word.
// Throughput: one word per cycle while full is low. An accepted word passes
// through the 6-stage transform, the mid queue and the 22-stage projection
// with its 17-step pipelined dividers.
// Receiver stall: the 32-word result queue absorbs the projection stages;
// once it would overflow, issue stops, the 8-word mid queue fills and full
// rises. Reset clears both queues and all valid bits and loads the register
// defaults (baseline 1 m, all else zero).
// Registers sit at byte address 8*index on the 64-bit APB-style port.
// Depends on slp_pkg, slp_front, slp_midq, slp_back, slp_outq.
`default_nettype none
module stereo_landmark_projection_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [9:0]         in_landmark_id,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_body_x,
  input  logic signed [31:0] in_body_y,
  input  logic signed [31:0] in_body_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         out_seen_id,
  output logic [15:0]        out_left_u,
  output logic [15:0]        out_left_v,
  output logic [15:0]        out_right_u,
  output logic [15:0]        out_right_v,
  output logic [15:0]        out_disparity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import slp_pkg::*;

  logic [47:0] rot_a_r, rot_b_r, rot_c_r;
  logic [59:0] offset_r, intr_l_r, intr_r_r, sizes_r;
  logic [19:0] baseline_r;
  cfg_t        cfg;
  cfg_reg_t    reg_sel;
  logic        cfg_wr;

  logic        in_acc, out_acc;
  in_item_t    in_item;
  logic        mq_push, mq_pop, mq_empty;
  mid_item_t   mq_wdata, mq_rdata;
  logic        oq_push;
  out_item_t   oq_wdata, oq_rdata;

  assign reg_sel = cfg_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_a_r    <= '0;
      rot_b_r    <= '0;
      rot_c_r    <= '0;
      offset_r   <= '0;
      baseline_r <= 20'd4096;
      intr_l_r   <= '0;
      intr_r_r   <= '0;
      sizes_r    <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROT_A:    rot_a_r    <= pwdata[47:0];
        REG_ROT_B:    rot_b_r    <= pwdata[47:0];
        REG_ROT_C:    rot_c_r    <= pwdata[47:0];
        REG_OFFSET:   offset_r   <= pwdata[59:0];
        REG_BASELINE: baseline_r <= pwdata[19:0];
        REG_INTR_L:   intr_l_r   <= pwdata[59:0];
        REG_INTR_R:   intr_r_r   <= pwdata[59:0];
        REG_SIZES:    sizes_r    <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROT_A:    prdata = 64'(rot_a_r);
      REG_ROT_B:    prdata = 64'(rot_b_r);
      REG_ROT_C:    prdata = 64'(rot_c_r);
      REG_OFFSET:   prdata = 64'(offset_r);
      REG_BASELINE: prdata = 64'(baseline_r);
      REG_INTR_L:   prdata = 64'(intr_l_r);
      REG_INTR_R:   prdata = 64'(intr_r_r);
      REG_SIZES:    prdata = 64'(sizes_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{rot: {rot_c_r, rot_b_r, rot_a_r}, offset: offset_r,
                 baseline: baseline_r, intr_l: intr_l_r, intr_r: intr_r_r,
                 sizes: sizes_r};

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;
  assign in_item = '{id: in_landmark_id,
                     px: in_point_x, py: in_point_y, pz: in_point_z,
                     bx: in_body_x,  by: in_body_y,  bz: in_body_z,
                     qw: in_quat_w,  qx: in_quat_x,  qy: in_quat_y, qz: in_quat_z};

  slp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_acc  (in_acc),
    .in_item (in_item),
    .mq_pop  (mq_pop),
    .full    (full),
    .mq_push (mq_push),
    .mq_data (mq_wdata)
  );

  slp_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_wdata),
    .pop   (mq_pop),
    .dout  (mq_rdata),
    .empty (mq_empty)
  );

  slp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mq_empty (mq_empty),
    .mq_data  (mq_rdata),
    .mq_pop   (mq_pop),
    .oq_pop   (out_acc),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  slp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_wdata),
    .pop   (out_acc),
    .dout  (oq_rdata),
    .empty (empty)
  );

  assign out_seen_id   = oq_rdata.id;
  assign out_left_u    = oq_rdata.lu;
  assign out_left_v    = oq_rdata.lv;
  assign out_right_u   = oq_rdata.ru;
  assign out_right_v   = oq_rdata.rv;
  assign out_disparity = oq_rdata.disp;

endmodule
`default_nettype wire

### rtl/slp_checker.sv
// Port-level checks for the stereo landmark projection unit, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module slp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [9:0]  out_seen_id,
  input wire logic [15:0] out_left_u,
  input wire logic [15:0] out_right_u,
  input wire logic [15:0] out_disparity
);

  // Both queues come out of reset drained
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not idle after reset");

  // Disparity is the column difference and never exceeds the left column
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_disparity == 16'(out_left_u - out_right_u))
               && (out_left_u >= out_disparity))
    else $error("disparity does not match the columns");

  // A waiting word holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_seen_id) && $stable(out_disparity))
    else $error("result word changed while stalled");

endmodule

bind stereo_landmark_projection_unit slp_checker u_slp_checker (.*);
`default_nettype wire

### tb/stereo_landmark_projection_unit_chk.sv
// Scoreboard for the stereo landmark projection unit: snoops register writes,
// predicts the observation of each accepted landmark word and compares results.
// Depends on slp_pkg.
`timescale 1ns / 1ps
module stereo_landmark_projection_unit_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  slp_pkg::in_item_t  in_word,
  input  logic               empty,
  input  logic               pop,
  input  slp_pkg::out_item_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  import slp_pkg::*;

  logic [47:0] rot_row [3];
  logic [59:0] cam0_offset;
  logic [19:0] baseline;
  logic [59:0] intr_left;
  logic [59:0] intr_right;
  logic [59:0] sizes;

  out_item_t obs_q[$];

  assign pending = obs_q.size();

  function automatic longint rnd14(longint x);
    return (x + longint'(RND_HALF)) >>> 14;
  endfunction

  function automatic longint div_floor(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic bit pixel_in_view(longint xc, longint yc, longint zc,
                                       logic [59:0] intr, longint w, longint h,
                                       output longint u, output longint v);
    longint fx, fy, cx, cy;
    fx = intr[14:0];
    fy = intr[29:15];
    cx = intr[44:30];
    cy = intr[59:45];
    u = 0;
    v = 0;
    if (zc <= 0) return 0;
    u = div_floor(fx * xc, zc) + cx;
    v = div_floor(fy * yc, zc) + cy;
    if (u < 0 || u >= w * 16) return 0;
    if (v < 0 || v >= h * 16) return 0;
    return 1;
  endfunction

  function automatic bit observe(in_item_t it, output out_item_t obs);
    longint d[3], body[3], cam[3], rq[3][3];
    longint ww, xx, yy, zz, acc, e, ofs, lu, lv, ru, rv, disp;
    longint one;
    one = longint'(1) << 28;
    obs = '0;
    d[0] = longint'(it.px) - longint'(it.bx);
    d[1] = longint'(it.py) - longint'(it.by);
    d[2] = longint'(it.pz) - longint'(it.bz);
    ww = it.qw;
    xx = it.qx;
    yy = it.qy;
    zz = it.qz;
    rq[0][0] = one - 2 * (yy * yy + zz * zz);
    rq[0][1] = 2 * (xx * yy - ww * zz);
    rq[0][2] = 2 * (xx * zz + ww * yy);
    rq[1][0] = 2 * (xx * yy + ww * zz);
    rq[1][1] = one - 2 * (xx * xx + zz * zz);
    rq[1][2] = 2 * (yy * zz - ww * xx);
    rq[2][0] = 2 * (xx * zz - ww * yy);
    rq[2][1] = 2 * (yy * zz + ww * xx);
    rq[2][2] = one - 2 * (xx * xx + yy * yy);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        rq[i][j] = rnd14(rq[i][j]);
    // world to body uses the transpose
    for (int i = 0; i < 3; i++)
      body[i] = rnd14(rq[0][i] * d[0] + rq[1][i] * d[1] + rq[2][i] * d[2]);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        e = $signed(rot_row[i][16*j +: 16]);
        acc += e * body[j];
      end
      ofs = $signed(cam0_offset[20*i +: 20]);
      cam[i] = rnd14(acc) + ofs * 16;
    end
    if (!pixel_in_view(cam[0], cam[1], cam[2], intr_left, sizes[11:0], sizes[23:12],
                       lu, lv))
      return 0;
    if (!pixel_in_view(cam[0] - longint'(baseline) * 16, cam[1], cam[2], intr_right,
                       sizes[35:24], sizes[47:36], ru, rv))
      return 0;
    disp = lu - ru;
    if (disp <= longint'(sizes[59:48])) return 0;
    obs.id   = it.id;
    obs.lu   = lu[15:0];
    obs.lv   = lv[15:0];
    obs.ru   = ru[15:0];
    obs.rv   = rv[15:0];
    obs.disp = disp[15:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t obs, exp_w;
    if (!rst_n) begin
      foreach (rot_row[i]) rot_row[i] = '0;
      cam0_offset = '0;
      baseline    = 20'd4096;
      intr_left   = '0;
      intr_right  = '0;
      sizes       = '0;
      fail_count  = 0;
      obs_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[5:3]))
          REG_ROT_A:    rot_row[0]  = pwdata[47:0];
          REG_ROT_B:    rot_row[1]  = pwdata[47:0];
          REG_ROT_C:    rot_row[2]  = pwdata[47:0];
          REG_OFFSET:   cam0_offset = pwdata[59:0];
          REG_BASELINE: baseline    = pwdata[19:0];
          REG_INTR_L:   intr_left   = pwdata[59:0];
          REG_INTR_R:   intr_right  = pwdata[59:0];
          REG_SIZES:    sizes       = pwdata[59:0];
          default: ;
        endcase
      end
      if (push && !full && observe(in_word, obs))
        obs_q = {obs_q, obs};
      if (pop && !empty) begin
        if (obs_q.size() == 0) begin
          $error("unexpected result word, id %0d", out_word.id);
          fail_count++;
        end else begin
          exp_w = obs_q.pop_front();
          if (out_word.id !== exp_w.id) begin
            $error("seen_id exp %0d got %0d", exp_w.id, out_word.id);
            fail_count++;
          end
          if (out_word.lu !== exp_w.lu) begin
            $error("left_u exp %0d got %0d", exp_w.lu, out_word.lu);
            fail_count++;
          end
          if (out_word.lv !== exp_w.lv) begin
            $error("left_v exp %0d got %0d", exp_w.lv, out_word.lv);
            fail_count++;
          end
          if (out_word.ru !== exp_w.ru) begin
            $error("right_u exp %0d got %0d", exp_w.ru, out_word.ru);
            fail_count++;
          end
          if (out_word.rv !== exp_w.rv) begin
            $error("right_v exp %0d got %0d", exp_w.rv, out_word.rv);
            fail_count++;
          end
          if (out_word.disp !== exp_w.disp) begin
            $error("disparity exp %0d got %0d", exp_w.disp, out_word.disp);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/stereo_landmark_projection_unit_tb.sv
// Testbench top for the stereo landmark projection unit: clock, reset, register
// setup, landmark stimulus with random gaps and stalls, and the verdict.
// Depends on slp_pkg, the unit and stereo_landmark_projection_unit_chk.
`timescale 1ns / 1ps
module stereo_landmark_projection_unit_tb;
  import slp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    lm;
  logic        empty;
  logic        pop;
  out_item_t   seen;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles;
  bit          steady;
  int          stall_left;

  stereo_landmark_projection_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_landmark_id (lm.id),
    .in_point_x     (lm.px),
    .in_point_y     (lm.py),
    .in_point_z     (lm.pz),
    .in_body_x      (lm.bx),
    .in_body_y      (lm.by),
    .in_body_z      (lm.bz),
    .in_quat_w      (lm.qw),
    .in_quat_x      (lm.qx),
    .in_quat_y      (lm.qy),
    .in_quat_z      (lm.qz),
    .empty          (empty),
    .pop            (pop),
    .out_seen_id    (seen.id),
    .out_left_u     (seen.lu),
    .out_left_v     (seen.lv),
    .out_right_u    (seen.ru),
    .out_right_v    (seen.rv),
    .out_disparity  (seen.disp),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  stereo_landmark_projection_unit_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_word    (lm),
    .empty      (empty),
    .pop        (pop),
    .out_word   (seen),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: mostly ready, random drops, rare long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 149) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(20, 90);
    end else begin
      pop <= steady ? 1'b1 : ($urandom_range(0, 9) < 7);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_intr(cfg_reg_t idx, int fx, int fy, int cx, int cy);
    write_reg(idx, {4'd0, 15'(cy), 15'(cx), 15'(fy), 15'(fx)});
  endtask

  task automatic write_sizes(int w0, int h0, int w1, int h1, int min_disp);
    write_reg(REG_SIZES, {4'd0, 12'(min_disp), 12'(h1), 12'(w1), 12'(h0), 12'(w0)});
  endtask

  // Upright camera, 500 px focal length, 640x480 images, 12 cm baseline.
  task automatic write_nominal();
    write_reg(REG_ROT_A, 64'h0000_0000_4000);
    write_reg(REG_ROT_B, 64'h0000_4000_0000);
    write_reg(REG_ROT_C, 64'h4000_0000_0000);
    write_reg(REG_OFFSET, '0);
    write_reg(REG_BASELINE, 64'd491);
    write_intr(REG_INTR_L, 8000, 8000, 5120, 3840);
    write_intr(REG_INTR_R, 8000, 8000, 5120, 3840);
    write_sizes(640, 480, 640, 480, 8);
  endtask

  // Let the pipeline drain; dropped landmarks leave nothing to wait on.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(in_item_t it);
    bit taken;
    int gap;
    lm   <= it;
    push <= 1'b1;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    gap = 0;
    if (!steady)
      gap = ($urandom_range(0, 99) < 4) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t any_landmark();
    in_item_t it;
    it.id = 10'($urandom_range(0, 1023));
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.bx = $urandom;
    it.by = $urandom;
    it.bz = $urandom;
    it.qw = 16'($urandom_range(0, 32768) - 16384);
    it.qx = 16'($urandom_range(0, 32768) - 16384);
    it.qy = 16'($urandom_range(0, 32768) - 16384);
    it.qz = 16'($urandom_range(0, 32768) - 16384);
    return it;
  endfunction

  // Landmark 2..30 m ahead of a nearly level body, mostly inside the view cone.
  function automatic in_item_t ahead_landmark();
    in_item_t it;
    int dz;
    dz = $urandom_range(2 << 16, 30 << 16);
    it.id = 10'($urandom_range(0, 1023));
    it.bx = $urandom_range(0, 1 << 29) - (1 << 28);
    it.by = $urandom_range(0, 1 << 29) - (1 << 28);
    it.bz = $urandom_range(0, 1 << 29) - (1 << 28);
    it.px = it.bx + $urandom_range(0, dz) - dz / 2;
    it.py = it.by + $urandom_range(0, dz) - dz / 2;
    it.pz = it.bz + dz;
    it.qw = 16'(16384 - $urandom_range(0, 300));
    it.qx = 16'($urandom_range(0, 1000) - 500);
    it.qy = 16'($urandom_range(0, 1000) - 500);
    it.qz = 16'($urandom_range(0, 1000) - 500);
    return it;
  endfunction

  task automatic random_run(int n, int pct_ahead);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      send(($urandom_range(0, 99) < pct_ahead) ? ahead_landmark() : any_landmark());
    end
    steady = 1'b0;
    push <= 1'b0;
    drain();
  endtask

  task automatic directed_run();
    in_item_t it;
    it = ahead_landmark();
    it.px = it.bx; it.py = it.by; it.qw = 16384; it.qx = 0; it.qy = 0; it.qz = 0;
    send(it);                                  // straight ahead, principal point
    it.qw = 0;
    send(it);                                  // zero quaternion acts as identity
    it.qw = -16384;
    send(it);
    it.qw = 0; it.qy = 16384;
    send(it);                                  // half turn puts it behind
    it.qy = -16384;
    send(it);
    it.qy = 0; it.qx = 16384;
    send(it);
    it.qx = 0; it.qz = 16384;
    send(it);
    it.qz = -16384; it.qx = -16384;
    send(it);                                  // non-unit quaternion, used as is
    it.qw = 16384; it.qx = 0; it.qz = 0;
    it.pz = it.bz - (5 << 16);
    send(it);                                  // negative depth
    it.pz = it.bz;
    send(it);                                  // zero depth
    it.pz = it.bz + (3 << 16); it.px = it.bx + (2 << 16);
    send(it);                                  // off the right edge
    it.px = it.bx - (2 << 16);
    send(it);
    it.px = it.bx; it.pz = it.bz + (32000 << 16);
    send(it);                                  // far away, disparity below limit
    it.id = 10'h3ff;
    it.px = 32'h7fff_ffff; it.py = 32'h7fff_ffff; it.pz = 32'h7fff_ffff;
    it.bx = 32'h8000_0000; it.by = 32'h8000_0000; it.bz = 32'h8000_0000;
    send(it);                                  // largest world delta
    it.id = 10'h000;
    it.px = 32'h8000_0000; it.py = 32'h8000_0000; it.pz = 32'h8000_0000;
    it.bx = 32'h7fff_ffff; it.by = 32'h7fff_ffff; it.bz = 32'h7fff_ffff;
    send(it);
    it.qw = 16384; it.qx = 16384; it.qy = 16384; it.qz = 16384;
    send(it);
    it.qw = -16384; it.qx = -16384; it.qy = -16384; it.qz = -16384;
    send(it);
    push <= 1'b0;
    drain();
  endtask

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    lm      = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    steady  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero image sizes, nothing is in view
    random_run(15, 50);

    write_nominal();
    directed_run();
    random_run(500, 85);

    // zero-size right image
    write_sizes(640, 480, 0, 0, 0);
    random_run(30, 90);

    // offset camera, largest baseline, different right optics
    write_nominal();
    write_reg(REG_OFFSET, {4'd0, 20'h00800, 20'hff000, 20'h01000});
    write_reg(REG_BASELINE, 64'hfffff);
    write_intr(REG_INTR_R, 6000, 6400, 32767, 2000);
    write_sizes(4095, 4095, 4095, 4095, 0);
    random_run(150, 85);

    // zero focal length on cam0, smallest baseline
    write_nominal();
    write_reg(REG_BASELINE, 64'd1);
    write_intr(REG_INTR_L, 0, 0, 5120, 3840);
    write_intr(REG_INTR_R, 8000, 8000, 1000, 3840);
    write_sizes(640, 480, 640, 480, 0);
    random_run(150, 85);

    // saturated optics and the largest disparity limit
    write_nominal();
    write_intr(REG_INTR_L, 32767, 32767, 32767, 32767);
    write_intr(REG_INTR_R, 32767, 32767, 0, 0);
    write_sizes(4095, 4095, 4095, 4095, 4095);
    random_run(120, 85);

    // arbitrary register contents
    write_reg(REG_ROT_A, {$urandom, $urandom});
    write_reg(REG_ROT_B, {$urandom, $urandom});
    write_reg(REG_ROT_C, {$urandom, $urandom});
    write_reg(REG_OFFSET, {$urandom, $urandom});
    write_reg(REG_BASELINE, {$urandom, $urandom});
    write_reg(REG_INTR_L, {$urandom, $urandom});
    write_reg(REG_INTR_R, {$urandom, $urandom});
    write_reg(REG_SIZES, {$urandom, $urandom});
    random_run(150, 50);

    // camera turned half a circle about its axis, with a small offset
    write_nominal();
    write_reg(REG_ROT_A, 64'h0000_0000_c000);
    write_reg(REG_ROT_B, 64'h0000_c000_0000);
    write_reg(REG_OFFSET, {4'd0, 20'h00400, 20'h00200, 20'hffe00});
    write_reg(REG_BASELINE, 64'd819);
    random_run(600, 85);

    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
